/* design/assert_macros.svh */
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a trigger
`define ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

/* design/asp_pkg.sv */
// shared types and constants of the seven bit packer
`default_nettype none
package asp_pkg;

  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned LANE_W      = 7;
  localparam int unsigned GROUP_BYTES = 7;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned JOB_W       = CHAR_W * GROUP_BYTES;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // one burst of result bytes handed from the front to the back
  typedef struct packed {
    logic [JOB_W-1:0] data;     // byte k in bits [8k+7:8k]
    logic [IDX_W-1:0] last_idx; // index of the final byte of the burst
    logic             done;     // burst ends the string
  } asp_job_t;

endpackage
`default_nettype wire

/* design/asp_front.sv */
// front end: collects characters into groups and builds packed or raw bursts
`default_nettype none
module asp_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [asp_pkg::CHAR_W-1:0] in_tdata,
  input  wire logic                      in_tlast,
  input  wire logic                      q_full,
  output logic                           q_push,
  output asp_pkg::asp_job_t              q_job
);

  logic [asp_pkg::CHAR_W-1:0] grp_r [asp_pkg::GROUP_BYTES];
  logic [asp_pkg::IDX_W-1:0]  cnt_r, cnt_nxt;
  logic                       accept;
  logic                       grp_full;
  logic [asp_pkg::JOB_W-1:0]  packed_w, raw_w;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign grp_full  = (cnt_r == asp_pkg::IDX_W'(asp_pkg::GROUP_BYTES));

  // seven bit lanes back to back, bit 7 of every character dropped
  always_comb begin
    packed_w = '0;
    for (int k = 0; k < asp_pkg::GROUP_BYTES; k++) begin
      packed_w[k*asp_pkg::LANE_W +: asp_pkg::LANE_W] = grp_r[k][asp_pkg::LANE_W-1:0];
    end
    packed_w[asp_pkg::GROUP_BYTES*asp_pkg::LANE_W +: asp_pkg::LANE_W] =
      in_tdata[asp_pkg::LANE_W-1:0];
  end

  // raw tail: buffered bytes with the current byte in slot cnt
  always_comb begin
    raw_w = '0;
    for (int k = 0; k < asp_pkg::GROUP_BYTES; k++) begin
      if (asp_pkg::IDX_W'(k) == cnt_r) begin
        raw_w[k*asp_pkg::CHAR_W +: asp_pkg::CHAR_W] = in_tdata;
      end else begin
        raw_w[k*asp_pkg::CHAR_W +: asp_pkg::CHAR_W] = grp_r[k];
      end
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    q_push         = 1'b0;
    q_job.data     = raw_w;
    q_job.last_idx = cnt_r;
    q_job.done     = 1'b1;
    if (accept) begin
      if (grp_full) begin
        q_push         = 1'b1;
        q_job.data     = packed_w;
        q_job.last_idx = asp_pkg::IDX_W'(asp_pkg::GROUP_BYTES - 1);
        q_job.done     = in_tlast;
        cnt_nxt        = '0;
      end else if (!in_tlast) begin
        cnt_nxt = cnt_r + asp_pkg::IDX_W'(1);
      end else begin
        q_push  = 1'b1;
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !grp_full && !in_tlast) begin
      grp_r[cnt_r] <= in_tdata;
    end
  end

endmodule
`default_nettype wire

/* design/asp_queue.sv */
// short burst queue between front and back
`default_nettype none
module asp_queue #(
  parameter int unsigned DEPTH = asp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire asp_pkg::asp_job_t push_job,
  input  wire logic              pop,
  output asp_pkg::asp_job_t      pop_job,
  output logic                   full,
  output logic                   empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  asp_pkg::asp_job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

endmodule
`default_nettype wire

/* design/asp_back.sv */
// back end: walks a burst out one byte per cycle, unless out_tready stalls it, into the output register
`default_nettype none
module asp_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_empty,
  input  wire asp_pkg::asp_job_t          q_job,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [asp_pkg::CHAR_W-1:0]      out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  asp_pkg::asp_job_t          act_r;
  logic                       act_valid_r;
  logic [asp_pkg::IDX_W-1:0]  idx_r;
  logic                       out_valid_r;
  logic [asp_pkg::CHAR_W-1:0] out_byte_r;
  logic                       out_last_r, out_done_r;
  logic                       out_load, act_end, act_free;

  assign out_load = act_valid_r && (!out_valid_r || out_tready);
  assign act_end  = (idx_r == act_r.last_idx);
  // next burst may start in the cycle the current one sends its final byte
  assign act_free = !act_valid_r || (out_load && act_end);
  assign q_pop    = act_free && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        act_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (out_load && act_end) begin
        act_valid_r <= 1'b0;
      end else if (out_load) begin
        idx_r <= idx_r + asp_pkg::IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      act_r <= q_job;
    end
    if (out_load) begin
      out_byte_r <= act_r.data[idx_r*asp_pkg::CHAR_W +: asp_pkg::CHAR_W];
      out_last_r <= act_end;
      out_done_r <= act_end && act_r.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule
`default_nettype wire

/* design/ascii_seven_bit_packer.sv */
// Seven bit character packer. One character word is taken per cycle on the
// in_ channel. Every eighth character of a string completes a group and
// yields seven packed words holding the low seven bits of all eight
// characters back to back, least significant bit first; a string that ends
// inside a group yields its buffered characters raw, all eight bits kept.
// The front stage forms each burst in the cycle its last character arrives
// and puts it into a queue of QUEUE_DEPTH bursts; the back stage sends one
// word per cycle, unless out_tready stalls it, through a registered output
// after the active burst register. Sustained rate is one character per cycle
// for packed groups while the output is not stalled (seven words out per
// eight in); short strings can produce up to seven words from one character,
// and in_tready drops while the burst queue is full.
`default_nettype none
`include "assert_macros.svh"
module ascii_seven_bit_packer #(
  parameter int unsigned QUEUE_DEPTH = asp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [asp_pkg::CHAR_W-1:0] in_tdata,  // [7:0] in_char
  input  wire logic                       in_tlast,  // end_of_string
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [asp_pkg::CHAR_W-1:0]      out_tdata, // [7:0] out_byte
  output logic                            out_tlast, // run_last
  output logic                            out_tuser  // [0] stream_done
);

  logic              q_push, q_pop, q_full, q_empty;
  asp_pkg::asp_job_t push_job, pop_job;

  asp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  asp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  asp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_job      (pop_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `ASSERT_CLK(a_done_is_last, (out_tvalid && out_tuser) |-> out_tlast, "stream_done without run_last")
  `ASSERT_CLK(a_no_push_full, q_push |-> !q_full, "burst pushed into full queue")
  `ASSERT_CLK(a_eos_pushes, (in_tvalid && in_tready && in_tlast) |-> q_push, "string end made no burst")
  `ASSERT_NEXT(a_push_not_empty, q_push, !q_empty, "queue empty after push")

endmodule
`default_nettype wire

/* tb/ascii_seven_bit_packer_test.sv */
// testbench of the seven bit packer: random strings checked against a packing predictor
`timescale 1ns / 100ps
module ascii_seven_bit_packer_test;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned IDLE_PCT    = 18;
  localparam int unsigned TOTAL_CHARS = 330;

  typedef struct {
    logic [asp_pkg::CHAR_W-1:0] ch;
    bit                         eos;
  } char_word_t;

  typedef struct {
    logic [asp_pkg::CHAR_W-1:0] data;
    bit                         run_last;
    bit                         done;
  } packed_word_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [asp_pkg::CHAR_W-1:0] in_tdata = '0;
  logic                       in_tlast = 1'b0;
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [asp_pkg::CHAR_W-1:0] out_tdata;
  logic                       out_tlast;
  logic                       out_tuser;

  char_word_t   pending_chars[$];
  packed_word_t expected_words[$];
  logic [asp_pkg::CHAR_W-1:0] group_chars[asp_pkg::GROUP_BYTES];
  int unsigned  group_fill = 0;
  int unsigned  chars_sent = 0;
  int unsigned  stall_cycles = 0;
  bit           failed = 1'b0;
  bit           steady;

  ascii_seven_bit_packer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // no idling on either side in the middle of the run
  assign steady = (chars_sent >= 120) && (chars_sent < 220);

  function automatic void push_word(logic [asp_pkg::CHAR_W-1:0] data, bit run_last,
                                    bit done);
    packed_word_t w;
    w.data = data;
    w.run_last = run_last;
    w.done = done;
    expected_words.push_back(w);
  endfunction

  // expected words caused by one accepted character
  function automatic void pack_char(logic [asp_pkg::CHAR_W-1:0] ch, bit eos);
    logic [asp_pkg::LANE_W*(asp_pkg::GROUP_BYTES+1)-1:0] lanes;
    if (group_fill == asp_pkg::GROUP_BYTES) begin
      for (int k = 0; k < asp_pkg::GROUP_BYTES; k++)
        lanes[asp_pkg::LANE_W*k +: asp_pkg::LANE_W] = group_chars[k][asp_pkg::LANE_W-1:0];
      lanes[asp_pkg::LANE_W*asp_pkg::GROUP_BYTES +: asp_pkg::LANE_W] =
        ch[asp_pkg::LANE_W-1:0];
      for (int j = 0; j < asp_pkg::GROUP_BYTES; j++)
        push_word(lanes[asp_pkg::CHAR_W*j +: asp_pkg::CHAR_W], j == asp_pkg::GROUP_BYTES - 1,
                  (j == asp_pkg::GROUP_BYTES - 1) && eos);
      group_fill = 0;
    end else if (!eos) begin
      group_chars[group_fill] = ch;
      group_fill++;
    end else begin
      // short tail goes out raw, bit 7 kept
      for (int k = 0; k < group_fill; k++)
        push_word(group_chars[k], 1'b0, 1'b0);
      push_word(ch, 1'b1, 1'b1);
      group_fill = 0;
    end
  endfunction

  function automatic void queue_char(logic [asp_pkg::CHAR_W-1:0] ch, bit eos);
    char_word_t c;
    c.ch = ch;
    c.eos = eos;
    pending_chars.push_back(c);
  endfunction

  always @(posedge clk) begin : drive_chars
    char_word_t c;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pack_char(in_tdata, in_tlast);
        chars_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_chars.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          c = pending_chars.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= c.ch;
          in_tlast  <= c.eos;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_words
    packed_word_t w;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: out_byte 0x%02h", out_tdata);
          failed = 1'b1;
        end else begin
          w = expected_words.pop_front();
          if (out_tdata !== w.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", w.data, out_tdata);
            failed = 1'b1;
          end
          if (out_tlast !== w.run_last) begin
            $error("run_last: expected %0d, got %0d", w.run_last, out_tlast);
            failed = 1'b1;
          end
          if (out_tuser !== w.done) begin
            $error("stream_done: expected %0d, got %0d", w.done, out_tuser);
            failed = 1'b1;
          end
        end
      end
      out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned pick;
    int unsigned total;
    // full group with end mark, bit 7 set on the first character
    queue_char(8'hFF, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h00, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h55, 1'b0);
    queue_char(8'h2A, 1'b0);
    queue_char(8'h01, 1'b0);
    queue_char(8'hFE, 1'b1);
    // one character string
    queue_char(8'hC3, 1'b1);
    // longest short tail, raw with bit 7 kept
    queue_char(8'h00, 1'b0);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h41, 1'b0);
    queue_char(8'h80, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h20, 1'b0);
    queue_char(8'h9A, 1'b1);
    // full group without end mark, then a single tail character
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h7F, 1'b0);
    queue_char(8'h00, 1'b1);

    total = TOTAL_CHARS;
    while (pending_chars.size() < total) begin
      pick = $urandom_range(9);
      if (pick < 4)
        len = $urandom_range(1, asp_pkg::GROUP_BYTES);
      else if (pick < 7)
        len = (asp_pkg::GROUP_BYTES + 1) * $urandom_range(1, 3);
      else
        len = $urandom_range(1, 30);
      for (int i = 0; i < len; i++)
        queue_char(asp_pkg::CHAR_W'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                             : $urandom_range(127)),
                   i == len - 1);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_chars.size() > 0 || in_tvalid)
      @(posedge clk);
    while (expected_words.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    if (!failed && expected_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule

/* files.f */
+incdir+design
design/asp_pkg.sv
design/asp_front.sv
design/asp_queue.sv
design/asp_back.sv
design/ascii_seven_bit_packer.sv
tb/ascii_seven_bit_packer_test.sv
